// ===== rtl/saob_pkg.sv =====
// Shared constants and types for the straight-alpha source-over blender.
// Used by saob_divider and straight_alpha_over_blend; no dependencies.
package saob_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned E_W       = 16;  // effective alpha, src_alpha * coverage
  localparam int unsigned ANUM_W    = 24;  // output-alpha numerator
  localparam int unsigned CNUM_W    = 32;  // colour numerator
  localparam int unsigned NUM_W     = 34;  // rounded dividend 2n + den
  localparam int unsigned DEN_W     = 25;  // rounded divisor 2 * den
  localparam int unsigned LANES     = 4;   // red, green, blue, alpha
  localparam int unsigned Q_W       = 8;
  localparam int unsigned STEP_BITS = 2;   // quotient bits per divider stage
  localparam int unsigned DIV_STAGES = Q_W / STEP_BITS;

  localparam int unsigned LANE_R = 0;
  localparam int unsigned LANE_G = 1;
  localparam int unsigned LANE_B = 2;
  localparam int unsigned LANE_A = 3;

  localparam logic [E_W-1:0]   ALPHA_DEN     = E_W'(65025);
  localparam logic [DEN_W-1:0] ALPHA_DEN_X2  = DEN_W'(130050);

  // Side data that rides along with the divider pipeline.
  typedef struct packed {
    logic             pass;  // effective alpha is zero: destination goes out
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } saob_tag_t;

endpackage

// ===== rtl/straight_alpha_over_blend.sv =====
// Straight-alpha RGBA8 source-over blender, top level.
// Depends on saob_pkg and saob_divider.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one transaction per
//   pixel: destination RGBA, source RGB, source alpha and coverage.
//   Output channel (out_valid_o / out_ready_i) returns one transaction per
//   input transaction, in order: the blended RGBA.
//   Effective alpha e = src_alpha * coverage over 65025. Output alpha is
//   (255e + da(65025-e)) / 65025, each colour is the alpha-weighted mean of
//   source and destination; all quotients round to nearest, halves up.
//   When e is zero the destination pixel passes through unchanged.
// Throughput: one pixel per clock while the output is not stalled, set by a
//   fully pipelined datapath (three multiply/add stages, a divisor setup
//   stage, four radix-4 restoring divider stages and an output register).
// Reset: all valid bits clear; no transaction is in flight afterwards.
// Stall: when the output is held and not taken, the whole pipeline
//   freezes together and in_ready_o drops; nothing is lost or repeated.
module straight_alpha_over_blend
  import saob_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] dst_red_i,
  input  logic [PIX_W-1:0] dst_green_i,
  input  logic [PIX_W-1:0] dst_blue_i,
  input  logic [PIX_W-1:0] dst_alpha_i,
  input  logic [PIX_W-1:0] src_red_i,
  input  logic [PIX_W-1:0] src_green_i,
  input  logic [PIX_W-1:0] src_blue_i,
  input  logic [PIX_W-1:0] src_alpha_i,
  input  logic [PIX_W-1:0] coverage_i,

  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_red_o,
  output logic [PIX_W-1:0] out_green_o,
  output logic [PIX_W-1:0] out_blue_o,
  output logic [PIX_W-1:0] out_alpha_o
);

  // Global advance: the output slot is free or is being drained.
  logic adv;

  // Stage 1: effective alpha and destination color times destination alpha.
  logic                         s1_valid_q;
  logic [E_W-1:0]               s1_e_q;
  logic [2:0][E_W-1:0]          s1_dad_q;
  logic [2:0][PIX_W-1:0]        s1_src_q;
  logic [PIX_W-1:0]             s1_ad_q;
  saob_tag_t                    s1_tag_q;
  saob_tag_t                    s1_tag_d;

  // Stage 2: products against e and the inverse alpha.
  logic                         s2_valid_q;
  logic [E_W-1:0]               s2_e_q;
  logic [2:0][ANUM_W-1:0]       s2_se_q;
  logic [2:0][CNUM_W-1:0]       s2_dadinv_q;
  logic [ANUM_W-1:0]            s2_adinv_q;
  saob_tag_t                    s2_tag_q;
  logic [E_W-1:0]               s2_inv;

  // Stage 3: numerators.
  logic                         s3_valid_q;
  logic [2:0][CNUM_W-1:0]       s3_n_q;
  logic [ANUM_W-1:0]            s3_anum_q;
  saob_tag_t                    s3_tag_q;

  // Stage 4: rounded dividend and divisor per lane.
  logic                         s4_valid_q;
  logic [LANES-1:0][NUM_W-1:0]  s4_num_q;
  logic [LANES-1:0][DEN_W-1:0]  s4_den_q;
  saob_tag_t                    s4_tag_q;

  // Divider results.
  logic                         div_valid;
  logic [LANES-1:0][Q_W-1:0]    div_quot;
  saob_tag_t                    div_tag;

  // Output register.
  logic                         out_valid_q;
  logic [PIX_W-1:0]             out_red_q;
  logic [PIX_W-1:0]             out_green_q;
  logic [PIX_W-1:0]             out_blue_q;
  logic [PIX_W-1:0]             out_alpha_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // e is zero exactly when either factor is zero
  always_comb begin
    s1_tag_d.pass  = (src_alpha_i == '0) || (coverage_i == '0);
    s1_tag_d.red   = dst_red_i;
    s1_tag_d.green = dst_green_i;
    s1_tag_d.blue  = dst_blue_i;
    s1_tag_d.alpha = dst_alpha_i;
  end

  assign s2_inv = ALPHA_DEN - s1_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: 8x8 products
      s1_e_q      <= E_W'(src_alpha_i) * E_W'(coverage_i);
      s1_dad_q[0] <= E_W'(dst_red_i)   * E_W'(dst_alpha_i);
      s1_dad_q[1] <= E_W'(dst_green_i) * E_W'(dst_alpha_i);
      s1_dad_q[2] <= E_W'(dst_blue_i)  * E_W'(dst_alpha_i);
      s1_src_q[0] <= src_red_i;
      s1_src_q[1] <= src_green_i;
      s1_src_q[2] <= src_blue_i;
      s1_ad_q     <= dst_alpha_i;
      s1_tag_q    <= s1_tag_d;

      // stage 2: products against e and (65025 - e)
      s2_e_q     <= s1_e_q;
      s2_adinv_q <= ANUM_W'(s1_ad_q) * ANUM_W'(s2_inv);
      for (int c = 0; c < 3; c++) begin
        s2_se_q[c]     <= ANUM_W'(s1_src_q[c]) * ANUM_W'(s1_e_q);
        s2_dadinv_q[c] <= CNUM_W'(s1_dad_q[c]) * CNUM_W'(s2_inv);
      end
      s2_tag_q <= s1_tag_q;

      // stage 3: times 255 as shift minus value, then sum
      s3_anum_q <= ({s2_e_q, 8'd0} - ANUM_W'(s2_e_q)) + s2_adinv_q;
      for (int c = 0; c < 3; c++) begin
        s3_n_q[c] <= ({s2_se_q[c], 8'd0} - CNUM_W'(s2_se_q[c])) + s2_dadinv_q[c];
      end
      s3_tag_q <= s2_tag_q;

      // stage 4: round-half-up form (2n + d) / (2d)
      for (int c = 0; c < 3; c++) begin
        s4_num_q[c] <= {1'b0, s3_n_q[c], 1'b0} + NUM_W'(s3_anum_q);
        s4_den_q[c] <= {s3_anum_q, 1'b0};
      end
      s4_num_q[LANE_A] <= NUM_W'({s3_anum_q, 1'b0}) + NUM_W'(ALPHA_DEN);
      s4_den_q[LANE_A] <= ALPHA_DEN_X2;
      s4_tag_q         <= s3_tag_q;

      // output select
      if (div_tag.pass) begin
        out_red_q   <= div_tag.red;
        out_green_q <= div_tag.green;
        out_blue_q  <= div_tag.blue;
        out_alpha_q <= div_tag.alpha;
      end else begin
        out_red_q   <= div_quot[LANE_R];
        out_green_q <= div_quot[LANE_G];
        out_blue_q  <= div_quot[LANE_B];
        out_alpha_q <= div_quot[LANE_A];
      end
    end
  end

  saob_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_valid_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .tag_i   (s4_tag_q),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .tag_o   (div_tag)
  );

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign out_alpha_o = out_alpha_q;

endmodule

// ===== rtl/saob_divider.sv =====
// Pipelined restoring divider, four lanes, two quotient bits per stage.
// Depends on saob_pkg; dividend must be below 2**Q_W times the divisor.
module saob_divider
  import saob_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]      num_i,
  input  logic [LANES-1:0][DEN_W-1:0]      den_i,
  input  saob_tag_t                        tag_i,
  output logic                             valid_o,
  output logic [LANES-1:0][Q_W-1:0]        quot_o,
  output saob_tag_t                        tag_o
);

  logic [LANES-1:0][NUM_W-1:0] rem_in  [DIV_STAGES];
  logic [LANES-1:0][DEN_W-1:0] den_in  [DIV_STAGES];
  logic [LANES-1:0][Q_W-1:0]   quot_in [DIV_STAGES];
  saob_tag_t                   tag_in  [DIV_STAGES];
  logic                        v_in    [DIV_STAGES];

  logic [LANES-1:0][NUM_W-1:0] rem_d   [DIV_STAGES];
  logic [LANES-1:0][Q_W-1:0]   quot_d  [DIV_STAGES];

  logic [LANES-1:0][NUM_W-1:0] rem_q   [DIV_STAGES];
  logic [LANES-1:0][DEN_W-1:0] den_q   [DIV_STAGES];
  logic [LANES-1:0][Q_W-1:0]   quot_q  [DIV_STAGES];
  saob_tag_t                   tag_q   [DIV_STAGES];
  logic                        valid_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s]  = num_i;
      assign den_in[s]  = den_i;
      assign quot_in[s] = '0;
      assign tag_in[s]  = tag_i;
      assign v_in[s]    = valid_i;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign quot_in[s] = quot_q[s-1];
      assign tag_in[s]  = tag_q[s-1];
      assign v_in[s]    = valid_q[s-1];
    end

    always_comb begin
      logic [LANES-1:0][NUM_W-1:0] r;
      logic [LANES-1:0][Q_W-1:0]   q;
      logic [NUM_W-1:0]            trial;
      r = rem_in[s];
      q = quot_in[s];
      for (int l = 0; l < LANES; l++) begin
        for (int j = 0; j < STEP_BITS; j++) begin
          trial = NUM_W'(den_in[s][l]) << (Q_W - 1 - s * STEP_BITS - j);
          if (r[l] >= trial) begin
            r[l] = r[l] - trial;
            q[l] = {q[l][Q_W-2:0], 1'b1};
          end else begin
            q[l] = {q[l][Q_W-2:0], 1'b0};
          end
        end
      end
      rem_d[s]  = r;
      quot_d[s] = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_in[s];
        quot_q[s] <= quot_d[s];
        tag_q[s]  <= tag_in[s];
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign quot_o  = quot_q[DIV_STAGES-1];
  assign tag_o   = tag_q[DIV_STAGES-1];

endmodule

// ===== sim/tb_straight_alpha_over_blend.sv =====
// Self-checking testbench for straight_alpha_over_blend (straight-alpha RGBA8 source-over).
// Depends on saob_pkg and the blender RTL; a built-in integer predictor
// scores every output transaction in order.
module tb_straight_alpha_over_blend;
  timeunit 1ns;
  timeprecision 1ps;

  import saob_pkg::*;

  // One input transaction: destination pixel, source colour, alpha, coverage.
  typedef struct packed {
    logic [PIX_W-1:0] dst_red;
    logic [PIX_W-1:0] dst_green;
    logic [PIX_W-1:0] dst_blue;
    logic [PIX_W-1:0] dst_alpha;
    logic [PIX_W-1:0] src_red;
    logic [PIX_W-1:0] src_green;
    logic [PIX_W-1:0] src_blue;
    logic [PIX_W-1:0] src_alpha;
    logic [PIX_W-1:0] coverage;
  } blend_req_t;

  // One output transaction: the blended pixel.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } rgba_t;

  localparam longint unsigned FULL_SCALE   = 255;
  localparam longint unsigned EFF_DEN      = 65025;  // 255 * 255
  localparam int unsigned     PIPE_LATENCY = 8;
  localparam int unsigned     MAX_IDLE     = 17;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [PIX_W-1:0] dst_red_i   = '0;
  logic [PIX_W-1:0] dst_green_i = '0;
  logic [PIX_W-1:0] dst_blue_i  = '0;
  logic [PIX_W-1:0] dst_alpha_i = '0;
  logic [PIX_W-1:0] src_red_i   = '0;
  logic [PIX_W-1:0] src_green_i = '0;
  logic [PIX_W-1:0] src_blue_i  = '0;
  logic [PIX_W-1:0] src_alpha_i = '0;
  logic [PIX_W-1:0] coverage_i  = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PIX_W-1:0] out_red_o;
  logic [PIX_W-1:0] out_green_o;
  logic [PIX_W-1:0] out_blue_o;
  logic [PIX_W-1:0] out_alpha_o;

  rgba_t expected_pixels[$];  // blended pixels still owed by the DUT, oldest first
  int    error_count = 0;
  bit    full_rate   = 1'b0;  // set for the closing stretch: no idling on either side

  straight_alpha_over_blend i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dst_red_i   (dst_red_i),
    .dst_green_i (dst_green_i),
    .dst_blue_i  (dst_blue_i),
    .dst_alpha_i (dst_alpha_i),
    .src_red_i   (src_red_i),
    .src_green_i (src_green_i),
    .src_blue_i  (src_blue_i),
    .src_alpha_i (src_alpha_i),
    .coverage_i  (coverage_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Round-half-up quotient: floor((2n + d) / 2d).
  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic [PIX_W-1:0] sat8(longint unsigned v);
    return (v > FULL_SCALE) ? 8'hFF : v[PIX_W-1:0];
  endfunction

  // Source-over with straight alpha. Effective alpha e is src_alpha * coverage
  // over 65025; output alpha numerator is 255e + da(65025 - e), and each
  // colour is the alpha-weighted mean of source and destination.
  function automatic rgba_t blend_over(blend_req_t px);
    longint unsigned eff, inv, dst_a, alpha_num;
    longint unsigned src_c[3];
    longint unsigned dst_c[3];
    logic [PIX_W-1:0] mixed[3];
    rgba_t res;
    eff = longint'(px.src_alpha) * longint'(px.coverage);
    if (eff == 0) begin
      // nothing of the source lands: destination passes through untouched
      res.red   = px.dst_red;
      res.green = px.dst_green;
      res.blue  = px.dst_blue;
      res.alpha = px.dst_alpha;
      return res;
    end
    src_c = '{longint'(px.src_red), longint'(px.src_green), longint'(px.src_blue)};
    dst_c = '{longint'(px.dst_red), longint'(px.dst_green), longint'(px.dst_blue)};
    dst_a     = longint'(px.dst_alpha);
    inv       = EFF_DEN - eff;
    alpha_num = FULL_SCALE * eff + dst_a * inv;  // nonzero since eff > 0
    for (int c = 0; c < 3; c++) begin
      mixed[c] = sat8(round_div(FULL_SCALE * src_c[c] * eff + dst_c[c] * dst_a * inv,
                                alpha_num));
    end
    res.red   = mixed[0];
    res.green = mixed[1];
    res.blue  = mixed[2];
    res.alpha = sat8(round_div(alpha_num, EFF_DEN));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic blend_req_t make_pixel(
      logic [PIX_W-1:0] dr, logic [PIX_W-1:0] dg, logic [PIX_W-1:0] db,
      logic [PIX_W-1:0] da, logic [PIX_W-1:0] sr, logic [PIX_W-1:0] sg,
      logic [PIX_W-1:0] sb, logic [PIX_W-1:0] sa, logic [PIX_W-1:0] cv);
    blend_req_t px;
    px = {dr, dg, db, da, sr, sg, sb, sa, cv};
    return px;
  endfunction

  // Idle burst length before the next input transaction; mostly zero.
  function automatic int unsigned input_gap();
    if (full_rate || $urandom_range(0, 5) != 0) return 0;
    return $urandom_range(1, MAX_IDLE);
  endfunction

  // Random pixel, biased toward what compositing actually sees: full coverage,
  // opaque sources, extreme destination alpha, tiny effective alpha, and the
  // pass-through cases.
  function automatic blend_req_t random_pixel();
    blend_req_t px;
    px.dst_red   = 8'($urandom);
    px.dst_green = 8'($urandom);
    px.dst_blue  = 8'($urandom);
    px.dst_alpha = 8'($urandom);
    px.src_red   = 8'($urandom);
    px.src_green = 8'($urandom);
    px.src_blue  = 8'($urandom);
    px.src_alpha = 8'($urandom);
    px.coverage  = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: px.coverage = 8'hFF;  // image compositing
      4: begin
        if ($urandom_range(0, 1) != 0) px.src_alpha = '0;
        else px.coverage = '0;
      end
      5: begin
        px.src_alpha = 8'hFF;
        px.coverage  = 8'hFF;
      end
      6: px.dst_alpha = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      7: begin
        px.src_alpha = 8'($urandom_range(1, 3));
        px.dst_alpha = 8'($urandom_range(0, 2));
      end
      default: ;
    endcase
    return px;
  endfunction

  // Drive one pixel and hold it until the DUT takes it. Called at a rising
  // edge; returns at the edge on which the transaction was accepted.
  task automatic send_pixel(input blend_req_t px);
    int unsigned gap;
    gap = input_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    dst_red_i   <= px.dst_red;
    dst_green_i <= px.dst_green;
    dst_blue_i  <= px.dst_blue;
    dst_alpha_i <= px.dst_alpha;
    src_red_i   <= px.src_red;
    src_green_i <= px.src_green;
    src_blue_i  <= px.src_blue;
    src_alpha_i <= px.src_alpha;
    coverage_i  <= px.coverage;
    // ready is settled by the falling edge and holds until the next rising one
    do @(negedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(blend_over(px));
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero effective alpha from either factor: destination must come back as is.
  task automatic test_passthrough();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF));
    send_pixel(make_pixel(8'h12, 8'hA5, 8'h5A, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80));
    send_pixel(make_pixel(8'h01, 8'hFE, 8'h7F, 8'h01, 8'hC3, 8'h3C, 8'h99, 8'h7F, 8'h00));
  endtask

  // Opaque source at full coverage replaces the destination outright.
  task automatic test_opaque_source();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(8'h3D, 8'hC2, 8'h81, 8'h40, 8'h7E, 8'h01, 8'hFE, 8'hFF, 8'hFF));
  endtask

  // Partial alpha: smallest effective alpha (output alpha rounds to zero while
  // colour still follows the source), transparent and opaque destinations,
  // coverage scaling, and midpoints near rounding boundaries.
  task automatic test_partial_alpha_corners();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h01, 8'h01));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h01, 8'h01));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h01));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h40, 8'h00, 8'hFF, 8'h00, 8'hC0, 8'h80, 8'hFF));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h40, 8'hFF, 8'hFF, 8'h00, 8'hC0, 8'h80, 8'h80));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFE, 8'hFF));
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE));
    send_pixel(make_pixel(8'h55, 8'hAA, 8'h33, 8'h7F, 8'hCC, 8'h11, 8'hEE, 8'h7F, 8'hFF));
    send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 8'h80, 8'h81, 8'h7F, 8'h80, 8'h80, 8'h80));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01));
    send_pixel(make_pixel(8'hA0, 8'h0A, 8'h5F, 8'hC8, 8'h12, 8'hED, 8'h66, 8'h33, 8'hCC));
  endtask

  // Bulk random pixels with idle bursts on both sides.
  task automatic test_random_blend(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Closing stretch at full rate: no gaps from the sender, no stalls from the
  // receiver, so the pipeline runs one pixel per clock.
  task automatic test_full_rate(input int unsigned count);
    full_rate = 1'b1;
    repeat (count) send_pixel(random_pixel());
    in_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready with random stall bursts, quiet once full_rate is set
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      if (!full_rate && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  task automatic check_channel(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Output scoreboard. Outputs and ready are stable by the falling edge, so a
  // transaction seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    rgba_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("output transaction with no pixel outstanding");
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_channel("out_red",   want.red,   out_red_o);
        check_channel("out_green", want.green, out_green_o);
        check_channel("out_blue",  want.blue,  out_blue_o);
        check_channel("out_alpha", want.alpha, out_alpha_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_opaque_source();
    test_partial_alpha_corners();
    test_random_blend(1100);
    test_full_rate(330);

    // drain, then give the pipeline time to show any stray output
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_LATENCY + 4) @(posedge clk_i);

    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("straight_alpha_over_blend test passed");
    end else begin
      $display("straight_alpha_over_blend test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every transaction behind a
  // full idle burst on both sides).
  initial begin
    #10ms;
    $display("straight_alpha_over_blend test failed");
    $finish;
  end

endmodule
